// ===== hdl/mrds_pkg.sv =====
package mrds_pkg;

   localparam int IDX_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIFORM_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIFORM_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_MAXIMA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_TIME       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCATIONS       = 3'd4;

   typedef struct packed {
      logic        uniform_mode;
      logic [7:0]  uniform_max;
      logic [63:0] position_maxima;
      logic [3:0]  lead_time;
      logic [3:0]  locations;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] quotient;
      logic [IDX_W-1:0] next_index;
      logic [3:0]       count;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

endpackage

// ===== hdl/mrds_req_if.sv =====
interface mrds_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] enum_index;

   modport source (output valid, output enum_index, input ready);
   modport sink (input valid, input enum_index, output ready);
endinterface

// ===== hdl/mrds_rsp_if.sv =====
interface mrds_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  row_index;
   logic [2:0]  column_index;
   logic [7:0]  digit_value;
   logic        overflow;
   logic [31:0] next_index;
   logic        last;

   modport source (output valid, output row_index, output column_index,
                   output digit_value, output overflow, output next_index,
                   output last, input ready);
   modport sink (input valid, input row_index, input column_index,
                 input digit_value, input overflow, input next_index,
                 input last, output ready);
endinterface

// ===== hdl/mrds_front.sv =====
module mrds_front #(
   parameter int MAX_POSITIONS = 8,
   parameter int QW = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   mrds_req_if.sink                  req_ch,
   input  mrds_pkg::cfg_type         cfg,
   input  mrds_pkg::queue_status_type q_status,
   output logic                      push,
   output mrds_pkg::item_type        push_item
);

   localparam logic [mrds_pkg::IDX_W-1:0] INDEX_MASK =
      (QW >= mrds_pkg::IDX_W) ? {mrds_pkg::IDX_W{1'b1}} :
      ((mrds_pkg::IDX_W'(1) << QW) - mrds_pkg::IDX_W'(1));

   logic                 valid_ff, valid_in;
   mrds_pkg::item_type   item_ff, item_in;
   logic                 accept;
   logic [3:0]           lt_eff, loc_eff;
   logic [7:0]           product;
   logic [mrds_pkg::IDX_W-1:0] q_masked;

   assign push = valid_ff && q_status.not_full;
   assign req_ch.ready = !valid_ff || push;
   assign accept = req_ch.valid && req_ch.ready;
   assign push_item = item_ff;

   always_comb begin
      lt_eff = (cfg.lead_time == 4'd0) ? 4'd1 : cfg.lead_time;
      loc_eff = (cfg.locations == 4'd0) ? 4'd1 : cfg.locations;
      product = {4'd0, lt_eff} * {4'd0, loc_eff};
      q_masked = req_ch.enum_index & INDEX_MASK;
      item_in = item_ff;
      if (accept) begin
         item_in.quotient = q_masked;
         item_in.next_index = (q_masked + mrds_pkg::IDX_W'(1)) & INDEX_MASK;
         item_in.count = (product > 8'(MAX_POSITIONS)) ? 4'(MAX_POSITIONS) : product[3:0];
      end
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== hdl/mrds_queue.sv =====
module mrds_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mrds_pkg::item_type         push_item,
   input  logic                       pop,
   output mrds_pkg::item_type         head_item,
   output mrds_pkg::queue_status_type status
);

   mrds_pkg::item_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign status.not_empty = (fill_ff != 2'd0);
   assign status.not_full = (fill_ff != 2'd2);
   assign do_push = push && status.not_full;
   assign do_pop = pop && status.not_empty;
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/mrds_back.sv =====
module mrds_back #(
   parameter int QW = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mrds_pkg::cfg_type          cfg,
   input  mrds_pkg::item_type         head_item,
   input  mrds_pkg::queue_status_type q_status,
   output logic                       pop,
   mrds_rsp_if.source                 rsp_ch
);

   localparam int CW = $clog2(QW);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [7:0]    rem_ff, rem_in;
   logic [CW-1:0] bit_ff, bit_in;
   logic [2:0]    pos_ff, pos_in;
   logic [2:0]    row_ff, row_in;
   logic [3:0]    col_ff, col_in;
   logic [3:0]    count_ff, count_in;
   logic [31:0]   next_ff, next_in;

   logic          out_valid_ff, out_valid_in;
   logic [2:0]    out_row_ff, out_row_in;
   logic [2:0]    out_col_ff, out_col_in;
   logic [7:0]    out_digit_ff, out_digit_in;
   logic          out_ovf_ff, out_ovf_in;
   logic [31:0]   out_next_ff, out_next_in;
   logic          out_last_ff, out_last_in;

   logic          out_free;
   logic [7:0]    max_sel;
   logic [8:0]    radix;
   logic [8:0]    shifted;
   logic [8:0]    diff;
   logic          ge;
   logic          is_last;
   logic [3:0]    lt_eff;
   logic [3:0]    col_next;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign pop = (state_ff == ST_IDLE) && q_status.not_empty;

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.row_index = out_row_ff;
   assign rsp_ch.column_index = out_col_ff;
   assign rsp_ch.digit_value = out_digit_ff;
   assign rsp_ch.overflow = out_ovf_ff;
   assign rsp_ch.next_index = out_next_ff;
   assign rsp_ch.last = out_last_ff;

   always_comb begin
      max_sel = cfg.uniform_mode ? cfg.uniform_max : cfg.position_maxima[{pos_ff, 3'b000} +: 8];
      radix = {1'b0, max_sel} + 9'd1;
      shifted = {rem_ff, quo_ff[QW-1]};
      ge = (shifted >= radix);
      diff = shifted - radix;
      is_last = (({1'b0, pos_ff} + 4'd1) == count_ff);
      lt_eff = (cfg.lead_time == 4'd0) ? 4'd1 : cfg.lead_time;
      col_next = col_ff + 4'd1;

      state_in = state_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      pos_in = pos_ff;
      row_in = row_ff;
      col_in = col_ff;
      count_in = count_ff;
      next_in = next_ff;

      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_digit_in = out_digit_ff;
      out_ovf_in = out_ovf_ff;
      out_next_in = out_next_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               quo_in = head_item.quotient[QW-1:0];
               rem_in = 8'd0;
               bit_in = '0;
               pos_in = 3'd0;
               row_in = 3'd0;
               col_in = 4'd0;
               count_in = head_item.count;
               next_in = head_item.next_index;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[7:0] : shifted[7:0];
            quo_in = {quo_ff[QW-2:0], ge};
            bit_in = bit_ff + CW'(1);
            if (bit_ff == CW'(QW - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_row_in = row_ff;
               out_col_in = col_ff[2:0];
               out_digit_in = rem_ff;
               out_ovf_in = is_last && (quo_ff != '0);
               out_next_in = next_ff;
               out_last_in = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 3'd1;
                  if (col_next == lt_eff) begin
                     col_in = 4'd0;
                     row_in = row_ff + 3'd1;
                  end else begin
                     col_in = col_next;
                  end
                  rem_in = 8'd0;
                  bit_in = '0;
                  state_in = ST_DIV;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      pos_ff <= pos_in;
      row_ff <= row_in;
      col_ff <= col_in;
      count_ff <= count_in;
      next_ff <= next_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      out_digit_ff <= out_digit_in;
      out_ovf_ff <= out_ovf_in;
      out_next_ff <= out_next_in;
      out_last_ff <= out_last_in;
   end

   a_digit_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ({1'b0, rem_ff} < radix))
      else $error("digit not below radix");

   a_emit_holds_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !out_free) |=> (state_ff == ST_EMIT))
      else $error("result dropped while output busy");

   a_overflow_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ovf_ff) |-> out_last_ff)
      else $error("overflow flagged on a non-final result");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_DIV))
      else $error("pop did not start a division");

endmodule

// ===== hdl/mixed_radix_digit_splitter.sv =====
// the front register and the queue feed the shared restoring divider, which handles each position in turn
// (QW = min(INDEX_BITS, 32)) and produces one quotient bit per cycle
// the front accepts and queues up to three transactions while the divider is busy
// reset is synchronous, active high: clears control state and loads register defaults
module mixed_radix_digit_splitter #(
   parameter int MAX_POSITIONS = 8,
   parameter int INDEX_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   mrds_req_if.sink                           req_ch,
   mrds_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [mrds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int QW = (INDEX_BITS < mrds_pkg::IDX_W) ? INDEX_BITS : mrds_pkg::IDX_W;

   mrds_pkg::cfg_type          cfg_ff, cfg_in;
   mrds_pkg::queue_status_type q_status;
   mrds_pkg::item_type         push_item;
   mrds_pkg::item_type         head_item;
   logic                       push;
   logic                       pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mrds_pkg::CSR_UNIFORM_MODE:    cfg_in.uniform_mode = csr_wdata[0];
            mrds_pkg::CSR_UNIFORM_MAX:     cfg_in.uniform_max = csr_wdata[7:0];
            mrds_pkg::CSR_POSITION_MAXIMA: cfg_in.position_maxima = csr_wdata;
            mrds_pkg::CSR_LEAD_TIME:       cfg_in.lead_time = csr_wdata[3:0];
            mrds_pkg::CSR_LOCATIONS:       cfg_in.locations = csr_wdata[3:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.uniform_mode <= 1'b0;
         cfg_ff.uniform_max <= 8'd1;
         cfg_ff.position_maxima <= 64'd0;
         cfg_ff.lead_time <= 4'd1;
         cfg_ff.locations <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mrds_front #(
      .MAX_POSITIONS(MAX_POSITIONS),
      .QW(QW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .cfg(cfg_ff),
      .q_status(q_status),
      .push(push),
      .push_item(push_item)
   );

   mrds_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .pop(pop),
      .head_item(head_item),
      .status(q_status)
   );

   mrds_back #(
      .QW(QW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .head_item(head_item),
      .q_status(q_status),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule

// ===== dv/tb_mixed_radix_digit_splitter.sv =====
`timescale 1ns / 1ps
module tb_mixed_radix_digit_splitter;

   localparam int GRID_CELLS = 8;
   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_PHASES = 4;
   localparam int ITEMS_PER_PHASE = 13;

   typedef struct {
      logic [2:0]  row_index;
      logic [2:0]  column_index;
      logic [7:0]  digit_value;
      logic        overflow;
      logic [31:0] next_index;
      logic        last;
   } grid_digit_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [mrds_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mrds_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   mrds_req_if req_bus ();
   mrds_rsp_if rsp_bus ();

   mrds_pkg::cfg_type active_cfg;
   grid_digit_type    expected_digits[$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                req_idle_pct = 0;
   int                rsp_idle_pct = 0;
   int                hold_request = 0;

   mixed_radix_digit_splitter #(
      .MAX_POSITIONS(GRID_CELLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_mixed_radix_digit_splitter: errors");
         $finish;
      end
   end

   function automatic logic [63:0] random_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] with_noise(input logic [63:0] value, input int width);
      logic [63:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return (random_word64() & ~mask) | (value & mask);
   endfunction

   function automatic logic [31:0] random_index();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 255);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         2: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic void split_index(input logic [31:0] index);
      grid_digit_type  d;
      longint unsigned quotient;
      int unsigned     span;
      int unsigned     rows;
      int unsigned     total;
      int unsigned     radix;
      quotient = index;
      span = (active_cfg.lead_time == 0) ? 1 : active_cfg.lead_time;
      rows = (active_cfg.locations == 0) ? 1 : active_cfg.locations;
      total = span * rows;
      if (total > GRID_CELLS)
         total = GRID_CELLS;
      for (int t = 0; t < total; t++) begin
         if (active_cfg.uniform_mode)
            radix = active_cfg.uniform_max + 1;
         else
            radix = active_cfg.position_maxima[8*t +: 8] + 1;
         d.row_index = 3'(t / span);
         d.column_index = 3'(t % span);
         d.digit_value = 8'(quotient % radix);
         quotient = quotient / radix;
         d.last = (t == total - 1);
         d.overflow = d.last && (quotient != 0);
         d.next_index = index + 32'd1;
         expected_digits.push_back(d);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_digit();
      grid_digit_type want;
      if (expected_digits.size() == 0) begin
         $error("result transaction with nothing expected: digit_value 0x%0h",
                rsp_bus.digit_value);
         error_count++;
      end else begin
         want = expected_digits.pop_front();
         compare_field("row_index", want.row_index, rsp_bus.row_index);
         compare_field("column_index", want.column_index, rsp_bus.column_index);
         compare_field("digit_value", want.digit_value, rsp_bus.digit_value);
         compare_field("overflow", want.overflow, rsp_bus.overflow);
         compare_field("next_index", want.next_index, rsp_bus.next_index);
         compare_field("last", want.last, rsp_bus.last);
      end
   endfunction

   // result side: random stalls plus a long hold on request
   initial begin : result_sink
      int hold_left = 0;
      int stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            check_digit();
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_idle_pct > 0 && $urandom_range(1, 100) <= rsp_idle_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_index(input logic [31:0] index);
      if (req_idle_pct > 0 && $urandom_range(1, 100) <= req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.enum_index <= index;
      do @(posedge clock); while (!req_bus.ready);
      split_index(index);
   endtask

   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [mrds_pkg::CSR_IDX_W-1:0] index,
                                 input logic [mrds_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         mrds_pkg::CSR_UNIFORM_MODE:    active_cfg.uniform_mode = data[0];
         mrds_pkg::CSR_UNIFORM_MAX:     active_cfg.uniform_max = data[7:0];
         mrds_pkg::CSR_POSITION_MAXIMA: active_cfg.position_maxima = data;
         mrds_pkg::CSR_LEAD_TIME:       active_cfg.lead_time = data[3:0];
         mrds_pkg::CSR_LOCATIONS:       active_cfg.locations = data[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_shape(input logic mode, input logic [7:0] umax,
                             input logic [63:0] maxima, input logic [3:0] lead,
                             input logic [3:0] rows);
      wait_for_idle();
      write_register(mrds_pkg::CSR_UNIFORM_MODE, with_noise(mode, 1));
      write_register(mrds_pkg::CSR_UNIFORM_MAX, with_noise(umax, 8));
      write_register(mrds_pkg::CSR_POSITION_MAXIMA, maxima);
      write_register(mrds_pkg::CSR_LEAD_TIME, with_noise(lead, 4));
      write_register(mrds_pkg::CSR_LOCATIONS, with_noise(rows, 4));
   endtask

   task automatic test_reset_defaults();
      send_index(32'd0);
      send_index(32'd1);
      send_index(32'hFFFF_FFFF);
   endtask

   task automatic test_uniform_radix();
      load_shape(1'b1, 8'd255, 64'd0, 4'd8, 4'd1);
      send_index(32'hFFFF_FFFF);
      send_index(32'h1234_5678);
      load_shape(1'b1, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 4'd2);
      send_index(32'd5);
      load_shape(1'b1, 8'd1, 64'd0, 4'd4, 4'd2);
      send_index(32'hAAAA_AAAA);
      send_index(32'h5555_5555);
      send_index(32'h0000_00FF);
   endtask

   task automatic test_position_maxima();
      load_shape(1'b0, 8'd1, 64'hFF00_0701_FE80_0F02, 4'd2, 4'd4);
      send_index(32'h8000_0000);
      send_index(32'h7FFF_FFFF);
      send_index(32'hFFFF_FFFF);
      load_shape(1'b0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 4'd1);
      send_index(32'hDEAD_BEEF);
      send_index(32'd256);
   endtask

   task automatic test_grid_shapes();
      // zero sizes act as one, oversized grids stop at eight cells
      load_shape(1'b1, 8'd9, 64'd0, 4'd0, 4'd0);
      send_index(32'd12345);
      load_shape(1'b1, 8'd2, 64'd0, 4'd15, 4'd1);
      send_index(32'hFFFF_FFFF);
      load_shape(1'b1, 8'd3, 64'd0, 4'd1, 4'd15);
      send_index(32'hC000_0001);
      load_shape(1'b0, 8'd3, 64'h0403_0201_0605_0807, 4'd3, 4'd3);
      send_index(32'hFFFF_FFFF);
      load_shape(1'b1, 8'd15, 64'd0, 4'd8, 4'd8);
      send_index(32'h0F0F_0F0F);
   endtask

   task automatic test_ignored_registers();
      load_shape(1'b0, 8'd7, 64'h0302_0103_0201_0403, 4'd2, 4'd4);
      wait_for_idle();
      for (int i = mrds_pkg::CSR_LOCATIONS + 1; i < 2**mrds_pkg::CSR_IDX_W; i++)
         write_register(mrds_pkg::CSR_IDX_W'(i), '1);
      send_index(32'h0BAD_F00D);
      send_index(32'hFFFF_FFFE);
   endtask

   task automatic test_backpressure();
      load_shape(1'b1, 8'd3, 64'd0, 4'd8, 4'd1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 600;
      for (int i = 0; i < 8; i++)
         send_index(random_index());
   endtask

   task automatic test_drain_pause();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      for (int i = 0; i < 3; i++)
         send_index(random_index());
      wait_for_idle();
      for (int i = 0; i < 3; i++)
         send_index(random_index());
   endtask

   task automatic test_random_items();
      logic [7:0]  umax;
      logic [63:0] maxima;
      logic [3:0]  lead;
      logic [3:0]  rows;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: umax = 8'd0;
            1: umax = 8'd255;
            default: umax = 8'($urandom_range(1, 254));
         endcase
         case ($urandom_range(0, 3))
            0: maxima = 64'hFFFF_FFFF_FFFF_FFFF;
            1: maxima = 64'd0;
            default: maxima = random_word64();
         endcase
         lead = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
         rows = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
         load_shape(1'($urandom_range(0, 1)), umax, maxima, lead, rows);
         req_idle_pct = (phase == 0) ? 0 : $urandom_range(10, 40);
         rsp_idle_pct = (phase == 0) ? 0 : $urandom_range(10, 40);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            send_index(random_index());
      end
   endtask

   task automatic test_quiet_tail();
      load_shape(1'b0, 8'd1, random_word64(), 4'd4, 4'd2);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int i = 0; i < 15; i++)
         send_index(random_index());
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.enum_index = '0;
      active_cfg = '0;
      active_cfg.uniform_max = 8'd1;
      active_cfg.lead_time = 4'd1;
      active_cfg.locations = 4'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_uniform_radix();
      test_position_maxima();
      test_grid_shapes();
      test_ignored_registers();
      test_backpressure();
      test_drain_pause();
      test_random_items();
      test_quiet_tail();
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_mixed_radix_digit_splitter: clean");
      else
         $display("tb_mixed_radix_digit_splitter: errors");
      $finish;
   end

endmodule
